>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> src/gpd_pkg.sv
// Types and constants of the glyph point decoder.
// No dependencies.
package gpd_pkg;
  localparam int unsigned PtMax = 64;
  typedef logic [4:0] flag_t;
  typedef enum logic [1:0] {PH_IDLE, PH_FLAGS, PH_X, PH_Y} phase_t;
  localparam logic [7:0] FL_ON = 8'h01;
  localparam logic [7:0] FL_XS = 8'h02;
  localparam logic [7:0] FL_YS = 8'h04;
  localparam logic [7:0] FL_REP = 8'h08;
  localparam logic [7:0] FL_XSAME = 8'h10;
  localparam logic [7:0] FL_YSAME = 8'h20;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       glyph_start;
    logic [6:0] point_count;
  } in_req_t;
  typedef struct packed {
    logic [5:0]  point_index;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic        on_curve;
    logic        tail_point;
    logic        overrun_error;
  } out_req_t;
endpackage

>>> src/gpd_if.sv
// Valid/ready channel interface carrying one request.
// Depends on gpd_pkg.
interface gpd_in_if;
  logic valid;
  logic ready;
  gpd_pkg::in_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gpd_out_if;
  logic valid;
  logic ready;
  gpd_pkg::out_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/gpd_fifo.sv
// Two-entry request queue between the in channel and the back part.
// Depends on gpd_pkg.
module gpd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  gpd_pkg::in_req_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output gpd_pkg::in_req_t rd_data
);
  gpd_pkg::in_req_t mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             wr, rd;
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> src/gpd_back.sv
// Back part: flag expansion, x and y decoding, point emission.
// Depends on gpd_pkg.
module gpd_back #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  gpd_pkg::in_req_t  req,
  output logic              res_valid,
  input  logic              res_ready,
  output gpd_pkg::out_req_t res
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  gpd_pkg::flag_t flag_mem [MAX_POINTS];
  logic [15:0]    x_mem [MAX_POINTS];

  gpd_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]  total_r, total_nxt, pc_r, pc_nxt;
  logic        rep_r, rep_nxt, hp_r, hp_nxt, ovr_r, ovr_nxt;
  gpd_pkg::flag_t cur_r, cur_nxt;
  logic [7:0]  hb_r, hb_nxt, rcnt_r, rcnt_nxt;
  logic [15:0] run_r, run_nxt;
  logic        fill_r, fill_nxt;
  gpd_pkg::out_req_t res_r, res_nxt;
  logic        rv_r, rv_nxt;
  gpd_pkg::flag_t f_rd_r;
  logic [15:0] x_rd_r;

  logic        take, fw_en, xw_en;
  logic [AW-1:0] fw_a, xw_a, ra, rd_a;
  gpd_pkg::flag_t fw_d, f;
  logic [15:0] xw_d;
  logic        ys, sh, sm, coord_ph, busy, done;
  logic [6:0]  cnt7, remain, pcv;
  logic [7:0]  b;

  assign ra = pc_r[AW-1:0];
  // The stores are read ahead into registers at the next point index.
  assign rd_a = pc_nxt[AW-1:0];
  assign f  = f_rd_r;
  assign coord_ph = (phase_r == gpd_pkg::PH_X) || (phase_r == gpd_pkg::PH_Y);
  assign ys = (phase_r == gpd_pkg::PH_Y);
  assign sh = ys ? f[2] : f[1];
  assign sm = ys ? f[4] : f[3];
  assign done = pc_r >= total_r;
  // Internal work steps run without a request: a repeat fill, a byte-less point or a pass end.
  assign busy = fill_r || (coord_ph && (done || (!sh && sm)));
  assign req_ready = !busy && !(rv_r && !res_ready);
  assign take = req_valid && req_ready;
  assign b = req.data_byte;
  assign remain = total_r - pc_r;
  assign res_valid = rv_r;
  assign res = res_r;

  always_comb begin
    phase_nxt = phase_r; total_nxt = total_r; pc_nxt = pc_r; rep_nxt = rep_r;
    hp_nxt = hp_r; ovr_nxt = ovr_r; cur_nxt = cur_r; hb_nxt = hb_r;
    run_nxt = run_r; fill_nxt = fill_r; rcnt_nxt = rcnt_r;
    fw_en = 1'b0; fw_a = ra; fw_d = cur_r; xw_en = 1'b0; xw_a = ra; xw_d = run_r;
    res_nxt = res_r; rv_nxt = rv_r && !res_ready;
    cnt7 = 7'd0; pcv = pc_r;
    if (fill_r) begin
      if (rcnt_r == 8'd0) begin
        fill_nxt = 1'b0;
        if (done) begin
          phase_nxt = gpd_pkg::PH_X; pc_nxt = '0; run_nxt = '0; hp_nxt = 1'b0;
        end
      end else begin
        fw_en = 1'b1; pc_nxt = pc_r + 7'd1; rcnt_nxt = rcnt_r - 8'd1;
      end
    end else if (coord_ph && done && !(rv_r && !res_ready)) begin
      pc_nxt = '0; run_nxt = '0; hp_nxt = 1'b0;
      phase_nxt = ys ? gpd_pkg::PH_IDLE : gpd_pkg::PH_Y;
    end else if (coord_ph && !done && !sh && sm) begin
      if (!ys) begin
        xw_en = 1'b1; pc_nxt = pc_r + 7'd1;
      end else if (!(rv_r && !res_ready)) begin
        rv_nxt = 1'b1; pc_nxt = pc_r + 7'd1;
        res_nxt = '{pc_r[5:0], x_rd_r, run_r, f[0], pc_r + 7'd1 == total_r, ovr_r};
      end
    end else if (take) begin
      if (req.glyph_start || phase_r == gpd_pkg::PH_FLAGS) begin
        if (req.glyph_start) begin
          cnt7 = req.point_count;
          if (cnt7 == 7'd0) cnt7 = 7'd1;
          if (cnt7 > 7'(MAX_POINTS)) cnt7 = 7'(MAX_POINTS);
          total_nxt = cnt7; pcv = '0; ovr_nxt = 1'b0; hb_nxt = '0; hp_nxt = 1'b0;
          run_nxt = '0; phase_nxt = gpd_pkg::PH_FLAGS; rep_nxt = 1'b0; cur_nxt = '0;
        end else cnt7 = total_r;
        if (rep_r && !req.glyph_start) begin
          rep_nxt = 1'b0;
          if ({1'b0, b} > {2'b0, remain}) begin
            rcnt_nxt = {1'b0, remain}; ovr_nxt = 1'b1;
          end else rcnt_nxt = b;
          fill_nxt = 1'b1;
        end else begin
          cur_nxt = {b[5], b[4], b[2:0]};
          fw_en = 1'b1; fw_a = pcv[AW-1:0]; fw_d = {b[5], b[4], b[2:0]};
          pc_nxt = pcv + 7'd1;
          rep_nxt = (b & gpd_pkg::FL_REP) != 8'd0;
          if (pcv + 7'd1 >= cnt7 && !rep_nxt) begin
            phase_nxt = gpd_pkg::PH_X; pc_nxt = '0;
          end
        end
      end else if (coord_ph && !done) begin
        if (sh) begin
          run_nxt = sm ? run_r + {8'd0, b} : run_r - {8'd0, b};
        end else if (!hp_r) begin
          hb_nxt = b; hp_nxt = 1'b1;
        end else begin
          hp_nxt = 1'b0; run_nxt = run_r + {hb_r, b};
        end
        if (sh || hp_r) begin
          pc_nxt = pc_r + 7'd1;
          if (!ys) begin
            xw_en = 1'b1; xw_d = run_nxt;
          end else begin
            rv_nxt = 1'b1;
            res_nxt = '{pc_r[5:0], x_rd_r, run_nxt, f[0],
                        pc_r + 7'd1 == total_r, ovr_r};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fw_en) flag_mem[fw_a] <= fw_d;
    if (xw_en) x_mem[xw_a] <= xw_d;
    if (fw_en && fw_a == rd_a) f_rd_r <= fw_d;
    else f_rd_r <= flag_mem[rd_a];
    if (xw_en && xw_a == rd_a) x_rd_r <= xw_d;
    else x_rd_r <= x_mem[rd_a];
    res_r <= res_nxt;
    hb_r <= hb_nxt; run_r <= run_nxt; cur_r <= cur_nxt; rcnt_r <= rcnt_nxt;
    if (!rst_n) begin
      phase_r <= gpd_pkg::PH_IDLE; total_r <= '0; pc_r <= '0; rep_r <= 1'b0;
      hp_r <= 1'b0; ovr_r <= 1'b0; fill_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; total_r <= total_nxt; pc_r <= pc_nxt; rep_r <= rep_nxt;
      hp_r <= hp_nxt; ovr_r <= ovr_nxt; fill_r <= fill_nxt; rv_r <= rv_nxt;
    end
  end
endmodule

>>> src/glyph_point_decoder_unit.sv
// Top level of the glyph point decoder.
// Depends on gpd_pkg, gpd_if, gpd_fifo and gpd_back.
//
// The in channel carries one request per glyph data byte; glyph_start marks
// the first flag byte and brings the point count. The out channel gives one
// request per point with x, y, on-curve, last-point and overrun bits.
// Requests enter a two-entry queue, so the source may run ahead of decoding.
// A byte that finishes a point puts the point in the output register, so a
// y point passes the queue and then the output register before it is valid.
// Each flag repeat count runs a fill step per repeated point plus a closing
// step, and each byte-less point and the end of the x pass and of the y pass
// take an internal step; no byte is taken during these steps. Reset is
// synchronous and empties the queue and output register.
// When the receiver stalls, the output register holds and the back part
// takes no byte, while the queue keeps taking bytes until it is full.
module glyph_point_decoder_unit #(
  parameter int unsigned MAX_POINTS = 64
) (
  input logic clk,
  input logic rst_n,
  gpd_in_if.sink    in_ch,
  gpd_out_if.source out_ch
);
  logic             q_valid, q_ready;
  gpd_pkg::in_req_t q_data;

  gpd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_ch.valid), .wr_ready(in_ch.ready), .wr_data(in_ch.data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  gpd_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
  );
endmodule

>>> src/gpd_checker.sv
// Port-level checks of the glyph point decoder, bound to the top level.
// Depends on assert_macros.svh and gpd_pkg.
`include "assert_macros.svh"
module gpd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input gpd_pkg::out_req_t out_data
);
  logic out_stall, out_top_idx;
  assign out_stall = out_valid && !out_ready;
  assign out_top_idx = out_valid && (out_data.point_index == 6'd63);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data), "result changed")
  `CHK_IMPLY(a_last_idx, clk, rst_n, out_top_idx, out_data.tail_point, "last flag missing")
  `CHK_NEXT(a_reset_out, clk, 1'b1, !rst_n, !out_valid, "result valid after reset")
  `CHK_NEXT(a_reset_in, clk, 1'b1, !rst_n, in_ready, "not ready after reset")
endmodule

bind glyph_point_decoder_unit gpd_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
